### rtl/csvfs_pkg.sv
package csvfs_pkg;

  // Character codes
  localparam logic [7:0] CH_NUL   = 8'd0;
  localparam logic [7:0] CH_LF    = 8'd10;
  localparam logic [7:0] CH_CR    = 8'd13;
  localparam logic [7:0] CH_QUOTE = 8'd34;
  localparam logic [7:0] CH_COMMA = 8'd44;

  // A field closes once it holds this many characters
  localparam logic [7:0] FIELD_CHAR_LIMIT = 8'd255;

  // Field count limits
  localparam logic [4:0] FIELD_CAP_MAX      = 5'd16;
  localparam logic [4:0] FIELD_LIMIT_RESET  = 5'd10;

  // Queue between front and back
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QUEUE_AW    = $clog2(QUEUE_DEPTH);

  typedef enum logic [1:0] {
    KIND_CHAR  = 2'd0,
    KIND_CLOSE = 2'd1,
    KIND_END   = 2'd2
  } kind_e;

  // One result beat
  typedef struct packed {
    kind_e      kind;
    logic [7:0] data_byte;
    logic [3:0] field_index;
    logic [7:0] amount;
  } result_t;

  // All results caused by one character: one or two beats
  typedef struct packed {
    result_t first;
    result_t second;
    logic    dual;
  } entry_t;

endpackage

### rtl/csvfs_front.sv
module csvfs_front import csvfs_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_valid_i,
  input  logic [4:0] cfg_data_i,
  input  logic       in_valid_i,
  input  logic [7:0] in_char_i,
  input  logic       push_ready_i,
  output logic       in_ready_o,
  output logic       push_valid_o,
  output entry_t     push_entry_o
);

  logic [4:0] field_limit_q;
  logic       quoted_q, quoted_d;
  logic [7:0] length_q, length_d;
  logic [4:0] done_q, done_d;
  logic       stopped_q, stopped_d;
  logic       after_sep_q, after_sep_d;

  logic [4:0] cap;
  logic       line_full;
  logic       is_eol;
  logic       accept;
  logic [7:0] length_inc;
  logic [4:0] done_inc;

  assign in_ready_o = push_ready_i;
  assign accept     = in_valid_i & push_ready_i;
  assign cap        = (field_limit_q > FIELD_CAP_MAX) ? FIELD_CAP_MAX : field_limit_q;
  assign line_full  = stopped_q | (done_q >= cap);
  assign is_eol     = (in_char_i == CH_NUL) | (in_char_i == CH_LF) | (in_char_i == CH_CR);
  assign length_inc = length_q + 8'd1;
  assign done_inc   = done_q + 5'd1;

  // Classify the character and build its result beats
  always_comb begin
    quoted_d     = quoted_q;
    length_d     = length_q;
    done_d       = done_q;
    stopped_d    = stopped_q;
    after_sep_d  = after_sep_q;
    push_valid_o = 1'b0;
    push_entry_o = '0;
    if (accept) begin
      if (is_eol) begin
        push_valid_o = 1'b1;
        if ((done_q < cap) && ((length_q != 8'd0) || after_sep_q)) begin
          // close the open or trailing empty field, then report the count
          push_entry_o.first  = '{KIND_CLOSE, 8'd0, done_q[3:0], length_q};
          push_entry_o.second = '{KIND_END, 8'd0, 4'd0, {3'b000, done_inc}};
          push_entry_o.dual   = 1'b1;
        end else begin
          push_entry_o.first = '{KIND_END, 8'd0, 4'd0, {3'b000, done_q}};
        end
        quoted_d    = 1'b0;
        length_d    = 8'd0;
        done_d      = 5'd0;
        stopped_d   = 1'b0;
        after_sep_d = 1'b0;
      end else if (!line_full) begin
        if (in_char_i == CH_QUOTE) begin
          quoted_d    = ~quoted_q;
          after_sep_d = 1'b0;
        end else if ((in_char_i == CH_COMMA) && !quoted_q) begin
          push_valid_o       = 1'b1;
          push_entry_o.first = '{KIND_CLOSE, 8'd0, done_q[3:0], length_q};
          done_d             = done_inc;
          length_d           = 8'd0;
          after_sep_d        = 1'b1;
        end else begin
          push_valid_o       = 1'b1;
          push_entry_o.first = '{KIND_CHAR, in_char_i, done_q[3:0], 8'd0};
          length_d           = length_inc;
          after_sep_d        = 1'b0;
          // length limit: close the field and stop the line
          if (length_inc >= FIELD_CHAR_LIMIT) begin
            push_entry_o.second = '{KIND_CLOSE, 8'd0, done_q[3:0], length_inc};
            push_entry_o.dual   = 1'b1;
            done_d              = done_inc;
            length_d            = 8'd0;
            stopped_d           = 1'b1;
          end
        end
      end
    end
  end

  // Hold line state and the field count register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      field_limit_q <= FIELD_LIMIT_RESET;
      quoted_q      <= 1'b0;
      length_q      <= 8'd0;
      done_q        <= 5'd0;
      stopped_q     <= 1'b0;
      after_sep_q   <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        field_limit_q <= cfg_data_i;
      end
      quoted_q    <= quoted_d;
      length_q    <= length_d;
      done_q      <= done_d;
      stopped_q   <= stopped_d;
      after_sep_q <= after_sep_d;
    end
  end

endmodule

### rtl/csvfs_queue.sv
module csvfs_queue import csvfs_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   push_valid_i,
  input  entry_t push_entry_i,
  output logic   push_ready_o,
  output logic   pop_valid_o,
  output entry_t pop_entry_o,
  input  logic   pop_i
);

  entry_t              slots_q [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr_q;
  logic [QUEUE_AW-1:0] rd_ptr_q;
  logic [QUEUE_AW:0]   count_q;
  logic                do_push;
  logic                do_pop;

  assign push_ready_o = (count_q != (QUEUE_AW+1)'(QUEUE_DEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign pop_entry_o  = slots_q[rd_ptr_q];
  assign do_push      = push_valid_i & push_ready_o;
  assign do_pop       = pop_i & pop_valid_o;

  // Write the entry at the tail
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slots_q[wr_ptr_q] <= push_entry_i;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + QUEUE_AW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + QUEUE_AW'(1);
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + (QUEUE_AW+1)'(1);
      end else if (do_pop && !do_push) begin
        count_q <= count_q - (QUEUE_AW+1)'(1);
      end
    end
  end

endmodule

### rtl/csvfs_back.sv
module csvfs_back import csvfs_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    entry_valid_i,
  input  entry_t  entry_i,
  output logic    pop_o,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  output result_t out_result_o,
  output logic    out_last_o
);

  logic sel_q;
  logic beat;

  // Pick the first or second beat of the head entry
  assign out_valid_o  = entry_valid_i;
  assign out_result_o = sel_q ? entry_i.second : entry_i.first;
  assign out_last_o   = sel_q | ~entry_i.dual;
  assign beat         = entry_valid_i & out_ready_i;
  assign pop_o        = beat & out_last_o;

  // Step through the beats of one entry
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sel_q <= 1'b0;
    end else if (beat) begin
      sel_q <= ~out_last_o;
    end
  end

endmodule

### rtl/csv_field_splitter_top.sv
// CSV field splitter. Takes one character per beat and splits lines into
// comma-separated fields: a double quote toggles quoted mode and is dropped,
// an unquoted comma closes the field, and NUL, LF or CR end the line, which
// closes an open or trailing empty field and then reports the field count.
// Every other character comes out with its field index. A field that reaches
// 255 characters is closed and the rest of its line ignored; once the field
// limit (at most 16) is reached, characters are ignored until the line end.
// Input takes one character per cycle unless the queue is full. Output gives
// one result beat per cycle while m_axis_tready is high; a character causes
// zero, one or two beats, tlast marks the last of them. A 4-entry queue
// between the classifier and the output sequencer absorbs bursts, so
// sustained input rate is one per cycle as long as characters average at
// most one result beat each; beyond that the queue fills and tready drops.
// Write the field limit only while the block is idle.
module csv_field_splitter_top import csvfs_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [4:0]  cfg_data_i,      // field limit
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,    // [7:0] char_in
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,    // [7:0] data_byte, [11:8] field_index,
                                       // [19:12] amount, [23:20] zero
  output logic [1:0]  m_axis_tuser,    // [1:0] kind
  output logic        m_axis_tlast     // last_of_run
);

  logic    push_valid;
  logic    push_ready;
  entry_t  push_entry;
  logic    head_valid;
  entry_t  head_entry;
  logic    pop;
  result_t out_result;

  assign cfg_ready_o = 1'b1;

  csvfs_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (s_axis_tvalid),
    .in_char_i    (s_axis_tdata),
    .push_ready_i (push_ready),
    .in_ready_o   (s_axis_tready),
    .push_valid_o (push_valid),
    .push_entry_o (push_entry)
  );

  csvfs_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_entry_i (push_entry),
    .push_ready_o (push_ready),
    .pop_valid_o  (head_valid),
    .pop_entry_o  (head_entry),
    .pop_i        (pop)
  );

  csvfs_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .entry_valid_i (head_valid),
    .entry_i       (head_entry),
    .pop_o         (pop),
    .out_valid_o   (m_axis_tvalid),
    .out_ready_i   (m_axis_tready),
    .out_result_o  (out_result),
    .out_last_o    (m_axis_tlast)
  );

  // Pack result fields
  assign m_axis_tdata = {4'd0, out_result.amount, out_result.field_index,
                         out_result.data_byte};
  assign m_axis_tuser = out_result.kind;

  // A line end is always the final beat of its character
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (m_axis_tuser == KIND_END)) |-> m_axis_tlast)
    else $error("line end beat without tlast");

  // The beat after a non-final beat is a field close or a line end
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tready && !m_axis_tlast) |=>
      (m_axis_tvalid && ((m_axis_tuser == KIND_CLOSE) || (m_axis_tuser == KIND_END))))
    else $error("second beat is not a close or line end");

  // Character beats never carry an amount
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (m_axis_tuser == KIND_CHAR)) |-> (m_axis_tdata[19:12] == 8'd0))
    else $error("character beat with nonzero amount");

  // Nothing is pushed into a full queue
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_valid |-> push_ready)
    else $error("push into full queue");

endmodule
